// File: hdl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared codes, defaults and control/status bundles of the cyclic timer bank.
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int ID_W     = 5;
    localparam int ATTR_W   = 3;
    localparam int PERIOD_W = 32;
    localparam int STATUS_W = 3;
    localparam int MASK_W   = 16;
    localparam int REMAIN_W = 32;

    localparam logic [MODE_W-1:0] MODE_TICK        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE_ID   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CREATE_AUTO = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_START       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STOP        = 3'd5;
    localparam logic [MODE_W-1:0] MODE_REFER       = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_SUP   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_EXIST = 3'd5;

    typedef struct packed {
        logic                latch;
        logic                scan_clr;
        logic                tick_issue;
        logic                find_step;
        logic                make_at_id;
        logic                make_at_scan;
        logic                del;
        logic                run_set;
        logic                run_clr;
        logic                refer_read;
        logic                emit;
        logic                sel_assigned;
        logic                sel_fired;
        logic                sel_refer;
        logic [STATUS_W-1:0] status_code;
    } ctb_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              id_ok;
        logic              attr_bad;
        logic              exists;
        logic              scan_free;
        logic              scan_last;
    } ctb_stat_t;

endpackage

// File: hdl/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl
// Command sequencer: decodes the latched command, walks the timer slots for
// ticks and lowest-free creates, and triggers the result transfer.
// ----------------------------------------------------------------------------
module ctb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ctb_pkg::ctb_stat_t stat,
    output ctb_pkg::ctb_cmd_t  cmd,
    output logic              busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_TICK   = 3'd2;
    localparam logic [2:0] S_TDRAIN = 3'd3;
    localparam logic [2:0] S_TFIN   = 3'd4;
    localparam logic [2:0] S_FIND   = 3'd5;
    localparam logic [2:0] S_REFER  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (stat.mode) inside
                    ctb_pkg::MODE_TICK:
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_TICK;
                    end
                    ctb_pkg::MODE_CREATE_ID:
                    begin
                        cmd.emit = 1'b1;
                        if (!stat.id_ok)
                        begin
                            cmd.status_code = ctb_pkg::ST_BAD_ID;
                        end
                        else if (stat.attr_bad)
                        begin
                            cmd.status_code = ctb_pkg::ST_NOT_SUP;
                        end
                        else if (stat.exists)
                        begin
                            cmd.status_code = ctb_pkg::ST_EXISTS;
                        end
                        else
                        begin
                            cmd.make_at_id  = 1'b1;
                            cmd.status_code = ctb_pkg::ST_OK;
                        end
                    end
                    ctb_pkg::MODE_CREATE_AUTO:
                    begin
                        if (stat.attr_bad)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.status_code = ctb_pkg::ST_NOT_SUP;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_FIND;
                        end
                    end
                    ctb_pkg::MODE_DELETE, ctb_pkg::MODE_START, ctb_pkg::MODE_STOP,
                    ctb_pkg::MODE_REFER:
                    begin
                        if (!stat.id_ok)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.status_code = ctb_pkg::ST_BAD_ID;
                        end
                        else if (!stat.exists)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.status_code = ctb_pkg::ST_NOT_EXIST;
                        end
                        else if (stat.mode == ctb_pkg::MODE_REFER)
                        begin
                            cmd.refer_read = 1'b1;
                            state_next     = S_REFER;
                        end
                        else
                        begin
                            cmd.emit        = 1'b1;
                            cmd.status_code = ctb_pkg::ST_OK;
                            cmd.del         = (stat.mode == ctb_pkg::MODE_DELETE);
                            cmd.run_set     = (stat.mode == ctb_pkg::MODE_START);
                            cmd.run_clr     = (stat.mode == ctb_pkg::MODE_STOP);
                        end
                    end
                    default:
                    begin
                        cmd.emit        = 1'b1;
                        cmd.status_code = ctb_pkg::ST_NOT_SUP;
                    end
                endcase
            end
            S_TICK:
            begin
                cmd.tick_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_TDRAIN;
                end
            end
            S_TDRAIN:
            begin
                state_next = S_TFIN;
            end
            S_TFIN:
            begin
                cmd.emit        = 1'b1;
                cmd.sel_fired   = 1'b1;
                cmd.status_code = ctb_pkg::ST_OK;
                state_next      = S_IDLE;
            end
            S_FIND:
            begin
                if (stat.scan_free)
                begin
                    cmd.make_at_scan = 1'b1;
                    cmd.emit         = 1'b1;
                    cmd.sel_assigned = 1'b1;
                    cmd.status_code  = ctb_pkg::ST_OK;
                    state_next       = S_IDLE;
                end
                else if (stat.scan_last)
                begin
                    cmd.emit        = 1'b1;
                    cmd.status_code = ctb_pkg::ST_NO_FREE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.find_step = 1'b1;
                end
            end
            S_REFER:
            begin
                cmd.emit        = 1'b1;
                cmd.sel_refer   = 1'b1;
                cmd.status_code = ctb_pkg::ST_OK;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/ctb_datapath.sv
// ----------------------------------------------------------------------------
// ctb_datapath
// Timer slot storage (flag vectors, period and count memories), slot scan
// with a two-stage read/update pipe, and the result registers.
// ----------------------------------------------------------------------------
module ctb_datapath
#(
    parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF,
    parameter int TIME_WIDTH = ctb_pkg::TIME_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctb_pkg::ctb_cmd_t              cmd,
    output ctb_pkg::ctb_stat_t             stat,
    input  logic [ctb_pkg::MODE_W-1:0]     mode,
    input  logic [ctb_pkg::ID_W-1:0]       timer_id,
    input  logic [ctb_pkg::ATTR_W-1:0]     attributes,
    input  logic [ctb_pkg::PERIOD_W-1:0]   period,
    output logic                           done,
    output logic [ctb_pkg::STATUS_W-1:0]   status,
    output logic [ctb_pkg::ID_W-1:0]       assigned_id,
    output logic [ctb_pkg::MASK_W-1:0]     fired_mask,
    output logic                           is_running,
    output logic [ctb_pkg::REMAIN_W-1:0]   remaining
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [ctb_pkg::MODE_W-1:0] mode_reg;
    logic [ctb_pkg::ID_W-1:0]   id_reg;
    logic [ctb_pkg::ATTR_W-1:0] attr_reg;
    logic [TIME_WIDTH-1:0]      period_reg;

    logic [NUM_TIMERS-1:0] created_reg;
    logic [NUM_TIMERS-1:0] running_reg;
    logic [NUM_TIMERS-1:0] fired_reg;

    logic [TIME_WIDTH-1:0] period_mem [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] count_mem  [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] period_rd_reg;
    logic [TIME_WIDTH-1:0] count_rd_reg;

    logic [IW-1:0] scan_reg;
    logic [IW-1:0] proc_idx_reg;
    logic          proc_vld_reg;

    logic                           done_reg;
    logic [ctb_pkg::STATUS_W-1:0]   status_reg;
    logic [ctb_pkg::ID_W-1:0]       assigned_reg;
    logic [ctb_pkg::MASK_W-1:0]     fired_out_reg;
    logic                           running_out_reg;
    logic [ctb_pkg::REMAIN_W-1:0]   remaining_reg;

    logic [6:0]            id_ext;
    logic [IW-1:0]         slot;
    logic [IW-1:0]         rd_addr;
    logic [IW:0]           scan_p1;
    logic [TIME_WIDTH-1:0] count_inc;
    logic                  hit;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [TIME_WIDTH-1:0] wr_count;
    logic [TIME_WIDTH-1:0] diff;

    assign id_ext    = {2'b00, id_reg};
    assign slot      = IW'(id_reg - 5'd1);
    assign rd_addr   = cmd.refer_read ? slot : scan_reg;
    assign scan_p1   = {1'b0, scan_reg} + {{IW{1'b0}}, 1'b1};
    assign count_inc = count_rd_reg + {{(TIME_WIDTH-1){1'b0}}, 1'b1};
    assign hit       = (count_inc == period_rd_reg);
    assign diff      = period_rd_reg - count_rd_reg;

    assign stat.mode      = mode_reg;
    assign stat.id_ok     = (id_ext != 7'd0) && (id_ext <= 7'(NUM_TIMERS));
    assign stat.attr_bad  = attr_reg[0] | attr_reg[2];
    assign stat.exists    = created_reg[slot];
    assign stat.scan_free = !created_reg[scan_reg];
    assign stat.scan_last = (scan_reg == IW'(NUM_TIMERS - 1));

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = proc_idx_reg;
        wr_count = hit ? '0 : count_inc;
        if (cmd.make_at_id)
        begin
            wr_en    = 1'b1;
            wr_addr  = slot;
            wr_count = '0;
        end
        else if (cmd.make_at_scan)
        begin
            wr_en    = 1'b1;
            wr_addr  = scan_reg;
            wr_count = '0;
        end
        else if (proc_vld_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg   <= mode;
            id_reg     <= timer_id;
            attr_reg   <= attributes;
            period_reg <= TIME_WIDTH'(period);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_count;
        end
        if (cmd.make_at_id || cmd.make_at_scan)
        begin
            period_mem[wr_addr] <= period_reg;
        end
        count_rd_reg  <= count_mem[rd_addr];
        period_rd_reg <= period_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            created_reg  <= '0;
            running_reg  <= '0;
            fired_reg    <= '0;
            scan_reg     <= '0;
            proc_idx_reg <= '0;
            proc_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            proc_vld_reg <= cmd.tick_issue && created_reg[scan_reg] && running_reg[scan_reg];
            proc_idx_reg <= scan_reg;
            done_reg     <= cmd.emit;
            if (cmd.scan_clr)
            begin
                scan_reg  <= '0;
                fired_reg <= '0;
            end
            else if (cmd.tick_issue || cmd.find_step)
            begin
                scan_reg <= scan_p1[IW-1:0];
            end
            if (proc_vld_reg && hit)
            begin
                fired_reg[proc_idx_reg] <= 1'b1;
            end
            if (cmd.make_at_id)
            begin
                created_reg[slot] <= 1'b1;
                running_reg[slot] <= attr_reg[1];
            end
            if (cmd.make_at_scan)
            begin
                created_reg[scan_reg] <= 1'b1;
                running_reg[scan_reg] <= attr_reg[1];
            end
            if (cmd.del)
            begin
                created_reg[slot] <= 1'b0;
                running_reg[slot] <= 1'b0;
            end
            if (cmd.run_set)
            begin
                running_reg[slot] <= 1'b1;
            end
            if (cmd.run_clr)
            begin
                running_reg[slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg      <= cmd.status_code;
            assigned_reg    <= cmd.sel_assigned ? ctb_pkg::ID_W'(scan_p1) : '0;
            fired_out_reg   <= cmd.sel_fired ? ctb_pkg::MASK_W'(fired_reg) : '0;
            running_out_reg <= cmd.sel_refer ? running_reg[slot] : 1'b0;
            remaining_reg   <= cmd.sel_refer ? ctb_pkg::REMAIN_W'(diff) : '0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign assigned_id = assigned_reg;
    assign fired_mask  = fired_out_reg;
    assign is_running  = running_out_reg;
    assign remaining   = remaining_reg;

endmodule

// File: hdl/cyclic_timer_bank.sv
// ----------------------------------------------------------------------------
// cyclic_timer_bank
// Bank of periodic timers driven by one command per transfer.
//
//   channel   | signals                                  | handshake
//   ----------+------------------------------------------+------------------
//   command   | mode, timer_id, attributes, period       | start & !busy
//   result    | status, assigned_id, fired_mask,         | done, one cycle
//             | is_running, remaining                    |
//
// Create, delete, start, stop and bad commands pass through the decode state
// before the registered result; refer adds a read state. Tick walks every
// slot, then a drain and a finish state; lowest-free create walks slots until
// the first free one or the last one. Both scans go one slot per cycle over
// the one-read, one-write period/count memories.
// Reset clears all timers; no clearing pass is needed.
// The result cannot be stalled; busy stays high until done is shown.
// ----------------------------------------------------------------------------
module cyclic_timer_bank
#(
    parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF,
    parameter int TIME_WIDTH = ctb_pkg::TIME_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ctb_pkg::MODE_W-1:0]     mode,
    input  logic [ctb_pkg::ID_W-1:0]       timer_id,
    input  logic [ctb_pkg::ATTR_W-1:0]     attributes,
    input  logic [ctb_pkg::PERIOD_W-1:0]   period,
    output logic                           done,
    output logic [ctb_pkg::STATUS_W-1:0]   status,
    output logic [ctb_pkg::ID_W-1:0]       assigned_id,
    output logic [ctb_pkg::MASK_W-1:0]     fired_mask,
    output logic                           is_running,
    output logic [ctb_pkg::REMAIN_W-1:0]   remaining
);

    ctb_pkg::ctb_cmd_t  cmd;
    ctb_pkg::ctb_stat_t stat;

    ctb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ctb_datapath
    #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .timer_id    (timer_id),
        .attributes  (attributes),
        .period      (period),
        .done        (done),
        .status      (status),
        .assigned_id (assigned_id),
        .fired_mask  (fired_mask),
        .is_running  (is_running),
        .remaining   (remaining)
    );

endmodule

// File: hdl/ctb_checker.sv
// ----------------------------------------------------------------------------
// ctb_checker
// Port-level checks of the timer bank command/result sequencing.
// ----------------------------------------------------------------------------
module ctb_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [ctb_pkg::STATUS_W-1:0]   status,
    input logic [ctb_pkg::ID_W-1:0]       assigned_id,
    input logic [ctb_pkg::MASK_W-1:0]     fired_mask,
    input logic                           is_running,
    input logic [ctb_pkg::REMAIN_W-1:0]   remaining
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command transfer did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("result shown without a command in progress");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("one command produced two results");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ctb_pkg::ST_OK) |->
            (assigned_id == '0) && (fired_mask == '0) && !is_running &&
            (remaining == '0))
        else $error("failed command returned nonzero data");

endmodule

bind cyclic_timer_bank ctb_checker u_ctb_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .assigned_id (assigned_id),
    .fired_mask  (fired_mask),
    .is_running  (is_running),
    .remaining   (remaining)
);

// File: verif/tb_cyclic_timer_bank.sv
// ----------------------------------------------------------------------------
// tb_cyclic_timer_bank
// Self-checking bench for the periodic timer bank. A directed opening covers
// bad ids, refused attributes, duplicate create, zero period, start in either
// state, stop, delete and the unused mode. Random traffic follows in
// alternating fill and churn phases, so the bank runs full, timers fire on
// ticks and every status comes back. A bit-accurate model of the bank
// predicts each reply, and every reply is checked field by field.
// ----------------------------------------------------------------------------
module tb_cyclic_timer_bank;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT          = ctb_pkg::NUM_TIMERS_DEF;
    localparam int RANDOM_CMDS = 950;
    localparam int STALL_LIMIT = 2000;

    typedef logic [ctb_pkg::MODE_W-1:0]   mode_t;
    typedef logic [ctb_pkg::ID_W-1:0]     id_t;
    typedef logic [ctb_pkg::ATTR_W-1:0]   attr_t;
    typedef logic [ctb_pkg::PERIOD_W-1:0] period_t;

    localparam mode_t MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic [ctb_pkg::STATUS_W-1:0] status;
        logic [ctb_pkg::ID_W-1:0]     assigned_id;
        logic [ctb_pkg::MASK_W-1:0]   fired_mask;
        logic                         is_running;
        logic [ctb_pkg::REMAIN_W-1:0] remaining;
    } reply_t;

    class timer_bank_ledger;
        bit          slot_made [NT];
        bit          slot_run  [NT];
        bit [31:0]   slot_len  [NT];
        bit [31:0]   slot_cnt  [NT];
        reply_t      pending_replies [$];
        int          failures;

        function void make_timer(int s, attr_t attr, period_t per);
            slot_made[s] = 1'b1;
            slot_run[s]  = attr[1];
            slot_len[s]  = per;
            slot_cnt[s]  = '0;
        endfunction

        function reply_t bank_reply(mode_t m, id_t id, attr_t attr, period_t per);
            reply_t r;
            bit     id_ok;
            bit     found;
            int     s;
            r     = '0;
            id_ok = (id >= 1) && (id <= NT);
            s     = id_ok ? int'(id) - 1 : 0;
            found = 1'b0;
            case (m) inside
                ctb_pkg::MODE_TICK:
                    for (int i = 0; i < NT; i++) begin
                        if (slot_made[i] && slot_run[i]) begin
                            slot_cnt[i] = slot_cnt[i] + 1;
                            if (slot_cnt[i] == slot_len[i]) begin
                                slot_cnt[i] = '0;
                                if (i < ctb_pkg::MASK_W)
                                    r.fired_mask[i] = 1'b1;
                            end
                        end
                    end
                ctb_pkg::MODE_CREATE_ID:
                    if (!id_ok)
                        r.status = ctb_pkg::ST_BAD_ID;
                    else if ((attr & 3'b101) != 0)
                        r.status = ctb_pkg::ST_NOT_SUP;
                    else if (slot_made[s])
                        r.status = ctb_pkg::ST_EXISTS;
                    else
                        make_timer(s, attr, per);
                ctb_pkg::MODE_CREATE_AUTO:
                    if ((attr & 3'b101) != 0)
                        r.status = ctb_pkg::ST_NOT_SUP;
                    else begin
                        r.status = ctb_pkg::ST_NO_FREE;
                        for (int i = 0; i < NT; i++) begin
                            if (!found && !slot_made[i]) begin
                                found         = 1'b1;
                                make_timer(i, attr, per);
                                r.status      = ctb_pkg::ST_OK;
                                r.assigned_id = id_t'(i + 1);
                            end
                        end
                    end
                ctb_pkg::MODE_DELETE, ctb_pkg::MODE_START, ctb_pkg::MODE_STOP,
                ctb_pkg::MODE_REFER:
                    if (!id_ok)
                        r.status = ctb_pkg::ST_BAD_ID;
                    else if (!slot_made[s])
                        r.status = ctb_pkg::ST_NOT_EXIST;
                    else if (m == ctb_pkg::MODE_DELETE) begin
                        slot_made[s] = 1'b0;
                        slot_run[s]  = 1'b0;
                        slot_len[s]  = '0;
                        slot_cnt[s]  = '0;
                    end
                    else if (m == ctb_pkg::MODE_START)
                        slot_run[s] = 1'b1;
                    else if (m == ctb_pkg::MODE_STOP)
                        slot_run[s] = 1'b0;
                    else begin
                        r.is_running = slot_run[s];
                        r.remaining  = slot_len[s] - slot_cnt[s];
                    end
                default:
                    r.status = ctb_pkg::ST_NOT_SUP;
            endcase
            return r;
        endfunction

        function void note_command(mode_t m, id_t id, attr_t attr, period_t per);
            pending_replies.push_back(bank_reply(m, id, attr, per));
        endfunction

        function void check_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                failures++;
            end
        endfunction

        function void check_reply(logic [ctb_pkg::STATUS_W-1:0] st,
                                  logic [ctb_pkg::ID_W-1:0] aid,
                                  logic [ctb_pkg::MASK_W-1:0] fm, logic run,
                                  logic [ctb_pkg::REMAIN_W-1:0] rem);
            reply_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with none outstanding, expected none, actual status %0h",
                         $time, st);
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            check_field("status", 32'(want.status), 32'(st));
            check_field("assigned_id", 32'(want.assigned_id), 32'(aid));
            check_field("fired_mask", 32'(want.fired_mask), 32'(fm));
            check_field("is_running", 32'(want.is_running), 32'(run));
            check_field("remaining", want.remaining, rem);
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    mode_t                        mode;
    id_t                          timer_id;
    attr_t                        attributes;
    period_t                      period;
    logic                         done;
    logic [ctb_pkg::STATUS_W-1:0] status;
    logic [ctb_pkg::ID_W-1:0]     assigned_id;
    logic [ctb_pkg::MASK_W-1:0]   fired_mask;
    logic                         is_running;
    logic [ctb_pkg::REMAIN_W-1:0] remaining;

    timer_bank_ledger    ledger;
    int                  idle_cycles;
    bit                  timed_out;

    cyclic_timer_bank dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            ledger.note_command(mode, timer_id, attributes, period);
        if (rst_n && done)
            ledger.check_reply(status, assigned_id, fired_mask, is_running, remaining);
    end

    // hold start high until the transfer edge
    task automatic send_command(mode_t m, id_t id, attr_t attr, period_t per);
        start      <= 1'b1;
        mode       <= m;
        timer_id   <= id;
        attributes <= attr;
        period     <= per;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pick_command(bit filling, output mode_t m, output id_t id,
                                output attr_t attr, output period_t per);
        int roll;
        roll = $urandom_range(0, 99);
        id   = ($urandom_range(0, 9) == 0) ? id_t'($urandom_range(0, 31))
                                            : id_t'($urandom_range(1, NT));
        attr = ($urandom_range(0, 4) == 0) ? attr_t'($urandom_range(0, 7))
                                            : ($urandom_range(0, 1) ? 3'b010 : 3'b000);
        case ($urandom_range(0, 19)) inside
            [0:1]:   per = '0;
            [2:4]:   per = $urandom;
            default: per = period_t'($urandom_range(1, 12));
        endcase
        if (roll < 30)
            m = ctb_pkg::MODE_TICK;
        else if (roll < 45)
            m = ctb_pkg::MODE_CREATE_ID;
        else if (roll < 55)
            m = ctb_pkg::MODE_CREATE_AUTO;
        else if (roll < 65)
            m = filling ? ctb_pkg::MODE_CREATE_AUTO : ctb_pkg::MODE_DELETE;
        else if (roll < 72)
            m = ctb_pkg::MODE_START;
        else if (roll < 79)
            m = ctb_pkg::MODE_STOP;
        else if (roll < 94)
            m = ctb_pkg::MODE_REFER;
        else begin
            m    = mode_t'($urandom_range(0, 7));
            id   = id_t'($urandom_range(0, 31));
            attr = attr_t'($urandom_range(0, 7));
            per  = $urandom;
        end
    endtask

    task automatic run_directed();
        send_command(ctb_pkg::MODE_TICK, 5'd0, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_CREATE_ID, 5'd1, 3'b010, 32'd1);
        send_command(ctb_pkg::MODE_CREATE_ID, 5'd16, 3'b000, 32'hFFFF_FFFF);
        send_command(ctb_pkg::MODE_CREATE_ID, 5'd0, 3'b000, 32'd5);
        send_command(ctb_pkg::MODE_CREATE_ID, 5'd17, 3'b000, 32'd5);
        send_command(ctb_pkg::MODE_CREATE_ID, 5'd31, 3'b111, 32'd5);
        send_command(ctb_pkg::MODE_CREATE_ID, 5'd2, 3'b001, 32'd5);
        send_command(ctb_pkg::MODE_CREATE_ID, 5'd2, 3'b100, 32'd5);
        send_command(ctb_pkg::MODE_CREATE_ID, 5'd1, 3'b000, 32'd5);
        send_command(ctb_pkg::MODE_CREATE_AUTO, 5'd9, 3'b010, 32'd0);
        send_command(ctb_pkg::MODE_CREATE_AUTO, 5'd0, 3'b101, 32'd3);
        send_command(ctb_pkg::MODE_CREATE_AUTO, 5'd0, 3'b011, 32'd2);
        send_command(ctb_pkg::MODE_TICK, 5'd31, 3'b111, 32'hFFFF_FFFF);
        send_command(ctb_pkg::MODE_REFER, 5'd1, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_REFER, 5'd2, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_REFER, 5'd16, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_START, 5'd16, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_STOP, 5'd1, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_START, 5'd16, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_TICK, 5'd0, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_REFER, 5'd16, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_DELETE, 5'd2, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_DELETE, 5'd2, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_STOP, 5'd9, 3'd0, 32'd0);
        send_command(MODE_UNUSED, 5'd4, 3'd0, 32'd0);
        send_command(ctb_pkg::MODE_REFER, 5'd0, 3'd0, 32'd0);
    endtask

    task automatic run_random();
        int      sent;
        int      burst;
        int      gap;
        mode_t   m;
        id_t     id;
        attr_t   attr;
        period_t per;
        sent = 0;
        while (sent < RANDOM_CMDS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++) begin
                pick_command(((sent / 120) % 2) == 0, m, id, attr, per);
                send_command(m, id, attr, per);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 20);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;
    endtask

    task automatic run_traffic();
        run_directed();
        run_random();
        while (ledger.pending_replies.size() != 0)
            @(posedge clk);
        repeat (NT + 8) @(posedge clk);
    endtask

    initial
    begin
        ledger     = new;
        timed_out  = 1'b0;
        rst_n      = 1'b0;
        start      <= 1'b0;
        mode       <= '0;
        timer_id   <= '0;
        attributes <= '0;
        period     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            run_traffic();
            begin
                wait (idle_cycles >= STALL_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        disable fork;
        if (timed_out)
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        if (ledger.pending_replies.size() != 0)
            $display("%0t: %0d replies outstanding, expected 0", $time,
                     ledger.pending_replies.size());
        if (!timed_out && ledger.failures == 0 && ledger.pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
hdl/ctb_pkg.sv
hdl/ctb_ctrl.sv
hdl/ctb_datapath.sv
hdl/cyclic_timer_bank.sv
hdl/ctb_checker.sv
verif/tb_cyclic_timer_bank.sv
